FILE: rtl/blsm_pkg.sv
// blsm_pkg: operation and status codes and shared types for the load/store memory
// no dependencies; used by the interfaces, the lane unit and the top level
package blsm_pkg;

    // operation codes
    localparam logic [2:0] OP_LB  = 3'd0;
    localparam logic [2:0] OP_LBU = 3'd1;
    localparam logic [2:0] OP_LH  = 3'd2;
    localparam logic [2:0] OP_LHU = 3'd3;
    localparam logic [2:0] OP_LW  = 3'd4;
    localparam logic [2:0] OP_SB  = 3'd5;
    localparam logic [2:0] OP_SH  = 3'd6;
    localparam logic [2:0] OP_SW  = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ALIGN = 2'd2;

    localparam int unsigned DATA_W = 32;

    typedef logic [2:0]               t_func;
    typedef logic [1:0]               t_status;
    typedef logic signed [DATA_W-1:0] t_sword;
    typedef logic [DATA_W-1:0]        t_word;

    // what the lane unit hands back to the top level
    typedef struct packed {
        t_sword  load_value;
        t_status status;
        logic    wr_en;
        t_word   wr_word;
    } t_lane_res;

endpackage

FILE: rtl/blsm_req_if.sv
// blsm_req_if: request channel, valid/ready with operation, address and store data
// depends on blsm_pkg
interface blsm_req_if
    import blsm_pkg::*;
();
    logic   valid;
    logic   ready;
    t_func  func;
    t_word  address;
    t_sword store_data;

    modport source (output valid, output func, output address, output store_data,
                    input ready);
    modport sink   (input valid, input func, input address, input store_data,
                    output ready);
endinterface

FILE: rtl/blsm_rsp_if.sv
// blsm_rsp_if: response channel, valid/ready with load value and status
// depends on blsm_pkg
interface blsm_rsp_if
    import blsm_pkg::*;
();
    logic    valid;
    logic    ready;
    t_sword  load_value;
    t_status status;

    modport source (output valid, output load_value, output status, input ready);
    modport sink   (input valid, input load_value, input status, output ready);
endinterface

FILE: rtl/blsm_ram.sv
// blsm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module blsm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/blsm_lane.sv
// blsm_lane: byte/halfword lane select, extension and store merge for one access
// depends on blsm_pkg
module blsm_lane
    import blsm_pkg::*;
(
    input  t_func     i_func,
    input  logic [1:0] i_addr_lo,
    input  logic      i_in_range,
    input  t_word     i_store_data,
    input  t_word     i_word,
    output t_lane_res o_res
);
    logic [7:0]  byte_sel;
    logic [15:0] half_sel;
    logic [4:0]  bshift;
    logic [4:0]  hshift;
    t_word       bmask;
    t_word       hmask;
    logic        misaligned;

    // lane selection
    assign bshift     = {i_addr_lo, 3'b000};
    assign hshift     = {i_addr_lo[1], 4'b0000};
    assign byte_sel   = 8'(i_word >> bshift);
    assign half_sel   = i_addr_lo[1] ? i_word[31:16] : i_word[15:0];
    assign bmask      = 32'h0000_00FF << bshift;
    assign hmask      = 32'h0000_FFFF << hshift;
    assign misaligned = i_addr_lo[0];

    // decode and merge
    always_comb begin
        o_res.load_value = '0;
        o_res.status     = ST_OK;
        o_res.wr_en      = 1'b0;
        o_res.wr_word    = i_word;
        if (!i_in_range) begin
            o_res.status = ST_RANGE;
        end else begin
            unique case (i_func) inside
                OP_LB:  o_res.load_value = t_sword'({{24{byte_sel[7]}}, byte_sel});
                OP_LBU: o_res.load_value = t_sword'({24'd0, byte_sel});
                OP_LH, OP_LHU: begin
                    if (misaligned) begin
                        o_res.load_value = '1;
                        o_res.status     = ST_ALIGN;
                    end else if (i_func == OP_LH) begin
                        o_res.load_value = t_sword'({{16{half_sel[15]}}, half_sel});
                    end else begin
                        o_res.load_value = t_sword'({16'd0, half_sel});
                    end
                end
                OP_LW:  o_res.load_value = t_sword'(i_word);
                OP_SB: begin
                    o_res.wr_en   = 1'b1;
                    o_res.wr_word = (i_word & ~bmask)
                                  | ({24'd0, i_store_data[7:0]} << bshift);
                end
                OP_SH: begin
                    // odd halfword store is flagged but still written
                    if (misaligned) begin
                        o_res.status = ST_ALIGN;
                    end
                    o_res.wr_en   = 1'b1;
                    o_res.wr_word = (i_word & ~hmask)
                                  | ({16'd0, i_store_data[15:0]} << hshift);
                end
                OP_SW: begin
                    o_res.wr_en   = 1'b1;
                    o_res.wr_word = i_store_data;
                end
                default: begin
                    o_res.wr_en = 1'b0;
                end
            endcase
        end
    end
endmodule

FILE: rtl/byte_addressed_load_store_memory.sv
// byte_addressed_load_store_memory: little-endian word memory for loads and stores
// flow: the ram read and stage one are registered when an item is accepted; the merged
//   result enters the output register when stage one advances, held while a reply waits
// throughput: one item per cycle while replies are taken; single ram read port plus
//   write-back of the merged word, last written word forwarded to a following access
// reset: clears pipeline and output valids; memory contents undefined until written
module byte_addressed_load_store_memory
    import blsm_pkg::*;
#(
    parameter int unsigned MEM_WORDS = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    blsm_req_if.sink   i_req,
    blsm_rsp_if.source o_rsp
);
    localparam int unsigned IDX_W      = $clog2(MEM_WORDS);
    localparam logic [29:0] WORD_LIMIT = 30'(MEM_WORDS);

    typedef logic [IDX_W-1:0] t_idx;

    // stage one (ram read outstanding) and output registers
    logic       r_s1_valid,  n_s1_valid;
    t_func      r_s1_func,   n_s1_func;
    logic [1:0] r_s1_lo,     n_s1_lo;
    t_idx       r_s1_idx,    n_s1_idx;
    t_word      r_s1_data,   n_s1_data;
    logic       r_s1_range,  n_s1_range;
    logic       r_fwd_hit,   n_fwd_hit;
    t_word      r_fwd_word,  n_fwd_word;
    logic       r_out_valid, n_out_valid;
    t_sword     r_out_value, n_out_value;
    t_status    r_out_stat,  n_out_stat;

    logic      accept;
    logic      s1_advance;
    logic      in_range;
    t_idx      in_idx;
    t_word     rd_word;
    t_word     cur_word;
    t_lane_res lane;

    // handshake
    assign s1_advance  = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_advance;
    assign accept      = i_req.valid && i_req.ready;

    // address decode
    assign in_range = i_req.address[31:2] < WORD_LIMIT;
    assign in_idx   = i_req.address[IDX_W+1:2];

    blsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s1_advance && lane.wr_en),
        .i_waddr (r_s1_idx),
        .i_wdata (lane.wr_word),
        .i_re    (accept && in_range),
        .i_raddr (in_idx),
        .o_rdata (rd_word)
    );

    // forwarded word covers a write that lands in the same cycle as the read
    assign cur_word = r_fwd_hit ? r_fwd_word : rd_word;

    blsm_lane u_lane (
        .i_func       (r_s1_func),
        .i_addr_lo    (r_s1_lo),
        .i_in_range   (r_s1_range),
        .i_store_data (r_s1_data),
        .i_word       (cur_word),
        .o_res        (lane)
    );

    // next state
    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1_func   = r_s1_func;
        n_s1_lo     = r_s1_lo;
        n_s1_idx    = r_s1_idx;
        n_s1_data   = r_s1_data;
        n_s1_range  = r_s1_range;
        n_fwd_hit   = r_fwd_hit;
        n_fwd_word  = r_fwd_word;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_stat  = r_out_stat;

        if (s1_advance) begin
            n_s1_valid = 1'b0;
        end
        if (accept) begin
            n_s1_valid = 1'b1;
            n_s1_func  = i_req.func;
            n_s1_lo    = i_req.address[1:0];
            n_s1_idx   = in_idx;
            n_s1_data  = i_req.store_data;
            n_s1_range = in_range;
            n_fwd_hit  = s1_advance && lane.wr_en && (r_s1_idx == in_idx);
            n_fwd_word = lane.wr_word;
        end

        if (s1_advance) begin
            n_out_valid = 1'b1;
            n_out_value = lane.load_value;
            n_out_stat  = lane.status;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1_func   <= n_s1_func;
        r_s1_lo     <= n_s1_lo;
        r_s1_idx    <= n_s1_idx;
        r_s1_data   <= n_s1_data;
        r_s1_range  <= n_s1_range;
        r_fwd_hit   <= n_fwd_hit;
        r_fwd_word  <= n_fwd_word;
        r_out_value <= n_out_value;
        r_out_stat  <= n_out_stat;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.load_value = r_out_value;
    assign o_rsp.status     = r_out_stat;
endmodule

FILE: bench/blsm_reply_check.sv
// blsm_reply_check: watches the request and response channels of the load/store memory,
// keeps a shadow copy of the memory and compares every reply with the predicted one
// depends on blsm_pkg, blsm_req_if, blsm_rsp_if
module blsm_reply_check
    import blsm_pkg::*;
#(
    parameter int unsigned MEM_WORDS = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    blsm_req_if  i_req,
    blsm_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_awaited
);

    localparam int unsigned IDX_W = $clog2(MEM_WORDS);
    localparam t_word BYTE_MASK = 32'h0000_00FF;
    localparam t_word HALF_MASK = 32'h0000_FFFF;

    typedef struct packed {
        t_sword  load_value;
        t_status status;
    } t_reply;

    // shadow of the memory array, only words already written are ever loaded or merged into
    t_word  shadow_mem [MEM_WORDS];
    t_reply awaited_rsp [$];

    // perform one access on the shadow memory and return the reply it gives
    function automatic t_reply access_memory(t_func func, t_word address, t_sword store_data);
        t_reply r;
        t_word  idx;
        t_word  word;
        t_word  mask;
        int     bshift;
        int     hshift;
        logic [7:0]  lane_b;
        logic [15:0] lane_h;
        logic [IDX_W-1:0] widx;
        r.load_value = '0;
        r.status     = ST_OK;
        idx          = address >> 2;
        // out of range: dropped, checked before alignment
        if (idx >= MEM_WORDS) begin
            r.status = ST_RANGE;
            return r;
        end
        widx   = idx[IDX_W-1:0];
        word   = shadow_mem[widx];
        bshift = int'(address[1:0]) * 8;
        hshift = int'(address[1]) * 16;
        lane_b = word[bshift +: 8];
        lane_h = word[hshift +: 16];
        case (func) inside
            OP_LB:  r.load_value = {{24{lane_b[7]}}, lane_b};
            OP_LBU: r.load_value = {24'd0, lane_b};
            OP_LH, OP_LHU: begin
                // odd halfword load answers all ones
                if (address[0]) begin
                    r.load_value = '1;
                    r.status     = ST_ALIGN;
                end else if (func == OP_LH) begin
                    r.load_value = {{16{lane_h[15]}}, lane_h};
                end else begin
                    r.load_value = {16'd0, lane_h};
                end
            end
            OP_LW:  r.load_value = word;
            OP_SB: begin
                mask = BYTE_MASK << bshift;
                shadow_mem[widx] = (word & ~mask) | ((t_word'(store_data) & BYTE_MASK) << bshift);
            end
            OP_SH: begin
                // odd halfword store is flagged but still written by address bit 1
                if (address[0]) r.status = ST_ALIGN;
                mask = HALF_MASK << hshift;
                shadow_mem[widx] = (word & ~mask) | ((t_word'(store_data) & HALF_MASK) << hshift);
            end
            default: shadow_mem[widx] = t_word'(store_data);
        endcase
        return r;
    endfunction

    // predict on accepted requests, compare on accepted replies
    always @(posedge i_clk) begin : watch
        t_reply want;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready)
                awaited_rsp.push_back(access_memory(i_req.func, i_req.address, i_req.store_data));
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_rsp.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, got load_value %h status %0d",
                             $time, i_rsp.load_value, i_rsp.status);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = awaited_rsp.pop_front();
                    if (i_rsp.load_value !== want.load_value) begin
                        $display("%0t: load_value mismatch, expected %h got %h",
                                 $time, want.load_value, i_rsp.load_value);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_rsp.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d got %0d",
                                 $time, want.status, i_rsp.status);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_awaited = awaited_rsp.size();
        end
    end

endmodule

FILE: bench/tb.sv
// tb: stimulus and verdict for byte_addressed_load_store_memory, directed then random
// accesses with random idling on both channels; checking is done in blsm_reply_check
// depends on blsm_pkg, blsm_req_if, blsm_rsp_if, blsm_reply_check and the rtl
module tb;
    import blsm_pkg::*;

    localparam int unsigned MEM_WORDS      = 4096;
    localparam int unsigned IDX_W          = $clog2(MEM_WORDS);
    localparam int          RANDOM_ITEMS   = 400;
    localparam int          HOLD_CYCLES    = 250;
    localparam int          TAIL_CYCLES    = 10;
    localparam int          WATCHDOG_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   awaited;
    int   idle_cycles = 0;
    bit   burst       = 1'b0;

    // words already written by a full word store, the only ones read
    bit          word_written [MEM_WORDS];
    int unsigned written_idx [$];

    blsm_req_if req_ch ();
    blsm_rsp_if rsp_ch ();

    byte_addressed_load_store_memory #(.MEM_WORDS(MEM_WORDS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    blsm_reply_check #(.MEM_WORDS(MEM_WORDS)) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_awaited    (awaited)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // offer one access after a random gap, none in a burst, and wait until it is taken
    task automatic issue(t_func func, t_word address, t_sword store_data);
        int   gap;
        t_word idx;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.address    <= address;
        req_ch.store_data <= store_data;
        do @(posedge i_clk); while (!req_ch.ready);
        idx = address >> 2;
        if (func == OP_SW && idx < MEM_WORDS && !word_written[idx[IDX_W-1:0]]) begin
            word_written[idx[IDX_W-1:0]] = 1'b1;
            written_idx.push_back(idx);
        end
    endtask

    // byte address inside a word that already holds defined data
    function automatic t_word written_addr();
        t_word idx;
        idx = written_idx[$urandom_range(0, written_idx.size() - 1)];
        return (idx << 2) | t_word'($urandom_range(0, 3));
    endfunction

    // random access: full word stores, out of range accesses, loads and sub-word stores on written words
    task automatic random_access();
        int     pick;
        t_func  func;
        t_word  address;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            address = (t_word'($urandom_range(0, MEM_WORDS - 1)) << 2) |
                      t_word'($urandom_range(0, 3));
            issue(OP_SW, address, $urandom);
        end else if (pick < 30) begin
            address = $urandom;
            if (address < MEM_WORDS * 4) address = address + MEM_WORDS * 4;
            func = t_func'($urandom_range(0, 7));
            issue(func, address, $urandom);
        end else begin
            func    = t_func'($urandom_range(0, 6));
            address = written_addr();
            // keep most halfword accesses aligned
            if ((func == OP_LH || func == OP_LHU || func == OP_SH) && $urandom_range(0, 3) != 0)
                address[0] = 1'b0;
            issue(func, address, $urandom);
        end
    endtask

    // reply side, random stalls with two long hold-offs
    initial begin : reply_side
        int stall;
        int replies;
        rsp_ch.ready <= 1'b0;
        replies = 0;
        forever begin
            replies = replies + 1;
            if (replies == 30 || replies == 300) stall = HOLD_CYCLES;
            else stall = burst ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                @(negedge i_clk);
                rsp_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    // reset, directed accesses, random accesses, verdict
    initial begin : stimulus
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= OP_LB;
        req_ch.address    <= '0;
        req_ch.store_data <= '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first and last word, lanes with both sign bits
        issue(OP_SW,  32'h0000_0000, 32'h80FF_7F01);
        issue(OP_SW,  32'h0000_3FFC, 32'h7FFF_8000);
        issue(OP_LB,  32'h0000_0000, '0);
        issue(OP_LB,  32'h0000_0002, '0);
        issue(OP_LBU, 32'h0000_0003, '0);
        issue(OP_LB,  32'h0000_0003, '0);
        issue(OP_LH,  32'h0000_0000, '0);
        issue(OP_LH,  32'h0000_0002, '0);
        issue(OP_LHU, 32'h0000_0002, '0);
        // odd halfword loads
        issue(OP_LH,  32'h0000_0001, '0);
        issue(OP_LHU, 32'h0000_0003, '0);
        issue(OP_LW,  32'h0000_0000, '0);
        // sub-word stores into the last word, one of them an odd halfword
        issue(OP_SB,  32'h0000_3FFD, 32'hFFFF_FFAB);
        issue(OP_SH,  32'h0000_3FFF, 32'h0000_1234);
        issue(OP_SH,  32'h0000_3FFC, 32'hFFFF_5678);
        issue(OP_LW,  32'h0000_3FFC, '0);
        // out of range, also with odd address
        issue(OP_SW,  32'h0000_4000, 32'h1234_5678);
        issue(OP_LW,  32'h0000_4000, '0);
        issue(OP_LB,  32'hFFFF_FFFF, '0);
        issue(OP_SB,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_LH,  32'h0000_4001, '0);
        // extreme store data
        issue(OP_SW,  32'h0000_0004, 32'h8000_0000);
        issue(OP_LW,  32'h0000_0004, '0);
        issue(OP_SW,  32'h0000_0008, 32'h7FFF_FFFF);
        issue(OP_LW,  32'h0000_0008, '0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            burst = (i % 80) < 20;
            // let everything drain once in the middle
            if (i == RANDOM_ITEMS / 2) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
                while (awaited != 0) @(negedge i_clk);
            end
            random_access();
        end

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (awaited != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && awaited == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/blsm_pkg.sv
rtl/blsm_req_if.sv
rtl/blsm_rsp_if.sv
rtl/blsm_ram.sv
rtl/blsm_lane.sv
rtl/byte_addressed_load_store_memory.sv
bench/blsm_reply_check.sv
bench/tb.sv
